// File: design/qs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_pkg
// Shared constants and pipeline record types for the quaternion slerp block.
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [16:0] QUARTER    = 17'd65536;
  localparam logic [15:0] THR_RESET  = 16'd32752;

  // sine polynomial coefficients, Q30
  localparam logic [30:0] SIN_A      = 31'd1686629713;
  localparam logic [30:0] SIN_B      = 31'd688904866;
  localparam logic [30:0] SIN_C      = 31'd76016977;

  localparam int          SQ_STEPS   = 32;
  localparam int          SRCH_STEPS = 17;
  localparam int          SIN_LAT    = 4;
  localparam int          DIV_STEPS  = 17;

  localparam logic [15:0] SAT_POS    = 16'h7fff;
  localparam logic [15:0] SAT_NEG    = 16'h8000;

  // item record carried down the main pipeline
  typedef struct packed {
    logic [3:0][16:0] a;    // first quaternion, sign-extended, may be negated
    logic [3:0][15:0] b;
    logic [15:0]      t;    // clamped blend fraction
    logic             lin;  // linear blend path
    logic [3:0][31:0] l;    // linear blend, Q30
    logic [30:0]      d;    // clamped dot magnitude, Q30
    logic [16:0]      p;    // angle, quarter turn = QUARTER
    logic [62:0]      v;    // square root remainder
    logic [62:0]      r;    // square root result
  } car_t;

  // divider stage record
  typedef struct packed {
    logic             lin;
    logic             zero;
    logic [3:0]       neg;
    logic [3:0]       sat;
    logic [31:0]      den;
    logic [3:0][47:0] rem;
    logic [3:0][16:0] q;
  } dv_t;

endpackage

// File: design/qs_sin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_sin
// Four-stage sine of a quarter-turn fraction, Q30 result.
// ----------------------------------------------------------------------------
module qs_sin import qs_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] p_i,
  output logic [30:0] sin_o
);

  logic [30:0] x0;
  logic [61:0] m0, m1, m2, m3;
  logic [30:0] x1_q, x2a_q, x2_q, x3_q, x2b_q, inner_q, mid_q, sin_q;
  logic [30:0] x2_d, inner_d, mid_d, sin_d;

  always_comb begin
    x0      = {p_i, 14'd0};
    m0      = x0 * x0;
    x2_d    = m0[60:30];
    m1      = x2_q * SIN_C;
    inner_d = SIN_B - m1[60:30];
    m2      = x2b_q * inner_q;
    mid_d   = SIN_A - m2[60:30];
    m3      = x3_q * mid_q;
    sin_d   = m3[60:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x0;
      x2_q    <= x2_d;
      x2a_q   <= x1_q;
      x2b_q   <= x2_q;
      inner_q <= inner_d;
      x3_q    <= x2a_q;
      mid_q   <= mid_d;
      sin_q   <= sin_d;
    end
  end

  assign sin_o = sin_q;

endmodule

// File: design/qs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qs_div
// Pipelined rounding divider for four lanes sharing one divisor, with Q1.15
// saturation of the signed quotient.
// ----------------------------------------------------------------------------
module qs_div import qs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic             lin_i,
  input  logic             zero_i,
  input  logic [3:0]       neg_i,
  input  logic [3:0][46:0] mag_i,
  input  logic [31:0]      den_i,
  output logic             vld_o,
  output logic             lin_o,
  output logic [3:0][15:0] r_o
);

  dv_t  st_d;
  dv_t  st_q  [DIV_STEPS+1];
  logic vld_q [DIV_STEPS+1];

  // add half the divisor for rounding, flag quotients past 17 bits
  always_comb begin
    logic [47:0] n;
    st_d      = '0;
    st_d.lin  = lin_i;
    st_d.zero = zero_i;
    st_d.neg  = neg_i;
    st_d.den  = den_i;
    for (int i = 0; i < 4; i++) begin
      n = {1'b0, mag_i[i]} + {17'd0, den_i[31:1]};
      st_d.rem[i] = n;
      st_d.sat[i] = ({1'b0, n} >= {den_i, 17'd0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int K = DIV_STEPS - 1 - j;
    dv_t nxt;

    always_comb begin
      logic [48:0] sh;
      nxt = st_q[j];
      sh  = {17'd0, st_q[j].den} << K;
      for (int i = 0; i < 4; i++) begin
        if ({1'b0, st_q[j].rem[i]} >= sh) begin
          nxt.rem[i]  = st_q[j].rem[i] - sh[47:0];
          nxt.q[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[j+1] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end
  end

  always_comb begin
    logic [16:0] q;
    logic [16:0] nq;
    for (int i = 0; i < 4; i++) begin
      q  = st_q[DIV_STEPS].q[i];
      nq = 17'd0 - q;
      if (st_q[DIV_STEPS].zero) begin
        r_o[i] = '0;
      end else if (st_q[DIV_STEPS].sat[i]) begin
        r_o[i] = st_q[DIV_STEPS].neg[i] ? SAT_NEG : SAT_POS;
      end else if (st_q[DIV_STEPS].neg[i]) begin
        r_o[i] = (q > 17'd32768) ? SAT_NEG : nq[15:0];
      end else begin
        r_o[i] = (q > 17'd32767) ? SAT_POS : q[15:0];
      end
    end
  end

  assign vld_o = vld_q[DIV_STEPS];
  assign lin_o = st_q[DIV_STEPS].lin;

endmodule

// File: design/quaternion_slerp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp_top
// Fixed-point quaternion slerp with a normalized linear blend near identity.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries quaternions a, b (Q1.15)
//   and the blend fraction t_frac_i (Q1.15, 32768 = 1.0). Output channel
//   (out_valid_o / out_ready_i) returns r (Q1.15, saturated) and
//   used_linear_o. The configuration channel writes linear_threshold through
//   cfg_data_i; it is always ready. The user must ensure it is written only
//   while the block is idle; the block itself does not enforce this. The
//   pipeline holds the 32-step square root, the 17-step arc cosine search
//   (five stages a step) and the 17-step divider. All stages move together:
//   one transaction is taken every cycle, and the pipeline advances,
//   whenever the output register is empty or being read, so a receiver stall
//   holds every stage and drops in_ready_o until the held result is taken.
//   Reset clears all valid bits and loads the threshold with 32752.
// ----------------------------------------------------------------------------
module quaternion_slerp_top import qs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] a_w_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic signed [15:0] b_w_i,
  input  logic        [15:0] t_frac_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] r_x_o,
  output logic signed [15:0] r_y_o,
  output logic signed [15:0] r_z_o,
  output logic signed [15:0] r_w_o,
  output logic               used_linear_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [15:0] cfg_data_i
);

  logic en;
  logic out_valid_q;
  logic [15:0] thr_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: capture, products, dot product, squares, sum of squares
  // --------------------------------------------------------------------------
  car_t car_a_d, car_a_q, car_b_q, car_c_d, car_c_q, car_d_d, car_d_q, car_e_d;
  logic va_q, vb_q, vc_q, vd_q;
  logic [3:0][31:0] pd_d, pd_q, la_d, la_q, lb_d, lb_q;
  logic signed [33:0] dot_d, dot_q;
  logic [3:0][60:0] sq_d, sq_q;

  always_comb begin
    car_a_d      = '0;
    car_a_d.a[0] = {a_x_i[15], a_x_i};
    car_a_d.a[1] = {a_y_i[15], a_y_i};
    car_a_d.a[2] = {a_z_i[15], a_z_i};
    car_a_d.a[3] = {a_w_i[15], a_w_i};
    car_a_d.b[0] = b_x_i;
    car_a_d.b[1] = b_y_i;
    car_a_d.b[2] = b_z_i;
    car_a_d.b[3] = b_w_i;
    car_a_d.t    = (t_frac_i > ONE_Q15) ? ONE_Q15 : t_frac_i;
  end

  always_comb begin
    logic signed [33:0] pw;
    logic signed [34:0] law;
    logic signed [34:0] lbw;
    logic [16:0] wt;
    wt = {1'b0, ONE_Q15} - {1'b0, car_a_q.t};
    for (int i = 0; i < 4; i++) begin
      pw  = $signed(car_a_q.a[i]) * $signed(car_a_q.b[i]);
      law = $signed(car_a_q.a[i]) * $signed({1'b0, wt});
      lbw = $signed(car_a_q.b[i]) * $signed({1'b0, car_a_q.t});
      pd_d[i] = pw[31:0];
      la_d[i] = law[31:0];
      lb_d[i] = lbw[31:0];
    end
  end

  always_comb begin
    car_c_d = car_b_q;
    dot_d   = $signed(pd_q[0]) + $signed(pd_q[1]) + $signed(pd_q[2]) + $signed(pd_q[3]);
    for (int i = 0; i < 4; i++) begin
      car_c_d.l[i] = la_q[i] + lb_q[i];
    end
    car_c_d.lin = (dot_d > $signed({3'b000, thr_q, 15'd0}));
  end

  // flip a onto the short arc, clamp the dot magnitude to one
  always_comb begin
    logic signed [63:0] sw;
    logic [33:0] dm;
    car_d_d = car_c_q;
    for (int i = 0; i < 4; i++) begin
      sw       = $signed(car_c_q.l[i]) * $signed(car_c_q.l[i]);
      sq_d[i]  = sw[60:0];
      if (!car_c_q.lin && dot_q[33]) car_d_d.a[i] = 17'd0 - car_c_q.a[i];
    end
    dm        = dot_q[33] ? 34'(-dot_q) : 34'(dot_q);
    car_d_d.d = (dm > {3'b000, ONE_Q30}) ? ONE_Q30 : dm[30:0];
    car_d_d.p = '0;
    car_d_d.v = '0;
    car_d_d.r = '0;
  end

  always_comb begin
    car_e_d   = car_d_q;
    car_e_d.v = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]} + {2'b00, sq_q[3]};
  end

  car_t rt_q  [SQ_STEPS+1];
  logic vrt_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      car_a_q  <= car_a_d;
      car_b_q  <= car_a_q;
      pd_q     <= pd_d;
      la_q     <= la_d;
      lb_q     <= lb_d;
      car_c_q  <= car_c_d;
      dot_q    <= dot_d;
      car_d_q  <= car_d_d;
      sq_q     <= sq_d;
      rt_q[0]  <= car_e_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      vc_q     <= 1'b0;
      vd_q     <= 1'b0;
      vrt_q[0] <= 1'b0;
    end else if (en) begin
      va_q     <= in_valid_i;
      vb_q     <= va_q;
      vc_q     <= vb_q;
      vd_q     <= vc_q;
      vrt_q[0] <= vd_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the linear blend length, one result bit per stage
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [62:0] RBIT = 63'(1) << (62 - 2 * j);
    car_t        rt_n;
    logic [62:0] rb;

    always_comb begin
      rt_n = rt_q[j];
      rb   = rt_q[j].r + RBIT;
      if (rt_q[j].v >= rb) begin
        rt_n.v = rt_q[j].v - rb;
        rt_n.r = (rt_q[j].r >> 1) + RBIT;
      end else begin
        rt_n.r = rt_q[j].r >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) rt_q[j+1] <= rt_n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vrt_q[j+1] <= 1'b0;
      end else if (en) begin
        vrt_q[j+1] <= vrt_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Arc cosine: bitwise search for the largest angle whose cosine covers d
  // --------------------------------------------------------------------------
  car_t sr_q  [1:SRCH_STEPS];
  logic vsr_q [1:SRCH_STEPS];

  for (genvar k = 0; k < SRCH_STEPS; k++) begin : g_acos
    localparam logic [16:0] SBIT = 17'(1) << (SRCH_STEPS - 1 - k);
    car_t        src;
    logic        vsrc;
    car_t        dl_q  [SIN_LAT];
    logic        vdl_q [SIN_LAT];
    logic [16:0] cand_in, cand_out, cos_arg;
    logic [30:0] cosv;
    car_t        sr_n;

    if (k == 0) begin : g_first
      assign src  = rt_q[SQ_STEPS];
      assign vsrc = vrt_q[SQ_STEPS];
    end else begin : g_next
      assign src  = sr_q[k];
      assign vsrc = vsr_q[k];
    end

    assign cand_in = src.p | SBIT;
    assign cos_arg = QUARTER - cand_in;

    qs_sin u_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .p_i   (cos_arg),
      .sin_o (cosv)
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[0] <= src;
        for (int m = 1; m < SIN_LAT; m++) dl_q[m] <= dl_q[m-1];
        sr_q[k+1] <= sr_n;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int m = 0; m < SIN_LAT; m++) vdl_q[m] <= 1'b0;
        vsr_q[k+1] <= 1'b0;
      end else if (en) begin
        vdl_q[0] <= vsrc;
        for (int m = 1; m < SIN_LAT; m++) vdl_q[m] <= vdl_q[m-1];
        vsr_q[k+1] <= vdl_q[SIN_LAT-1];
      end
    end

    // keep the candidate bit when the angle stays in range and cos >= d
    always_comb begin
      cand_out = dl_q[SIN_LAT-1].p | SBIT;
      sr_n     = dl_q[SIN_LAT-1];
      if (cand_out <= QUARTER && cosv >= dl_q[SIN_LAT-1].d) sr_n.p = cand_out;
    end
  end

  // --------------------------------------------------------------------------
  // Scaled angles, sines, weighted sums
  // --------------------------------------------------------------------------
  car_t        car_p_q;
  logic        vp_q;
  logic [16:0] p1_d, p2_d, p1_q, p2_q;

  always_comb begin
    logic [16:0] w1;
    logic [33:0] m1;
    logic [33:0] m2;
    w1   = {1'b0, ONE_Q15} - {1'b0, sr_q[SRCH_STEPS].t};
    m1   = w1 * sr_q[SRCH_STEPS].p + 34'd16384;
    m2   = sr_q[SRCH_STEPS].t * sr_q[SRCH_STEPS].p + 34'd16384;
    p1_d = m1[31:15];
    p2_d = m2[31:15];
  end

  logic [30:0] s0, s1, s2;

  qs_sin u_s0 (.clk_i(clk_i), .en_i(en), .p_i(car_p_q.p), .sin_o(s0));
  qs_sin u_s1 (.clk_i(clk_i), .en_i(en), .p_i(p1_q),      .sin_o(s1));
  qs_sin u_s2 (.clk_i(clk_i), .en_i(en), .p_i(p2_q),      .sin_o(s2));

  car_t fd_q  [SIN_LAT];
  logic vfd_q [SIN_LAT];

  car_t                   car_m_q;
  logic                   vm_q, zs_q;
  logic [30:0]            s0_q;
  logic [3:0][48:0]       ma_d, ma_q, mb_d, mb_q;
  logic                   zs_d;

  // zero sine falls back to the plain blend over 2^15
  always_comb begin
    logic [16:0] w1;
    logic [30:0] wa;
    logic [30:0] wb;
    w1   = {1'b0, ONE_Q15} - {1'b0, fd_q[SIN_LAT-1].t};
    zs_d = (s0 == '0);
    wa   = zs_d ? {14'd0, w1} : s1;
    wb   = zs_d ? {15'd0, fd_q[SIN_LAT-1].t} : s2;
    for (int i = 0; i < 4; i++) begin
      ma_d[i] = $signed(fd_q[SIN_LAT-1].a[i]) * $signed({1'b0, wa});
      mb_d[i] = $signed(fd_q[SIN_LAT-1].b[i]) * $signed({1'b0, wb});
    end
  end

  logic [3:0][46:0] mag_d, mag_q;
  logic [3:0]       neg_d, neg_q;
  logic [31:0]      den_d, den_q;
  logic             zero_d, zero_q, lin_q, vm2_q;

  always_comb begin
    logic signed [49:0] num;
    logic [49:0]        mg;
    logic [31:0]        lenv;
    for (int i = 0; i < 4; i++) begin
      num      = car_m_q.lin ? 50'($signed({car_m_q.l[i], 15'd0}))
                             : ($signed(ma_q[i]) + $signed(mb_q[i]));
      neg_d[i] = num[49];
      mg       = num[49] ? 50'(-num) : 50'(num);
      mag_d[i] = mg[46:0];
    end
    lenv   = car_m_q.r[31:0];
    zero_d = car_m_q.lin && (lenv == '0);
    if (car_m_q.lin) begin
      den_d = zero_d ? 32'd1 : lenv;
    end else begin
      den_d = zs_q ? {16'd0, ONE_Q15} : {1'b0, s0_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      car_p_q <= sr_q[SRCH_STEPS];
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      fd_q[0] <= car_p_q;
      for (int m = 1; m < SIN_LAT; m++) fd_q[m] <= fd_q[m-1];
      car_m_q <= fd_q[SIN_LAT-1];
      ma_q    <= ma_d;
      mb_q    <= mb_d;
      zs_q    <= zs_d;
      s0_q    <= s0;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      den_q   <= den_d;
      zero_q  <= zero_d;
      lin_q   <= car_m_q.lin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q  <= 1'b0;
      for (int m = 0; m < SIN_LAT; m++) vfd_q[m] <= 1'b0;
      vm_q  <= 1'b0;
      vm2_q <= 1'b0;
    end else if (en) begin
      vp_q     <= vsr_q[SRCH_STEPS];
      vfd_q[0] <= vp_q;
      for (int m = 1; m < SIN_LAT; m++) vfd_q[m] <= vfd_q[m-1];
      vm_q     <= vfd_q[SIN_LAT-1];
      vm2_q    <= vm_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divide, round, saturate, output register
  // --------------------------------------------------------------------------
  logic             dv_vld, dv_lin;
  logic [3:0][15:0] dv_r;

  qs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vm2_q),
    .lin_i  (lin_q),
    .zero_i (zero_q),
    .neg_i  (neg_q),
    .mag_i  (mag_q),
    .den_i  (den_q),
    .vld_o  (dv_vld),
    .lin_o  (dv_lin),
    .r_o    (dv_r)
  );

  logic [3:0][15:0] r_q;
  logic             ul_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q  <= dv_r;
      ul_q <= dv_lin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign r_x_o         = r_q[0];
  assign r_y_o         = r_q[1];
  assign r_z_o         = r_q[2];
  assign r_w_o         = r_q[3];
  assign used_linear_o = ul_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_on_held_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("pipeline stalled without a held result");

  a_angle_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vsr_q[SRCH_STEPS] |-> (sr_q[SRCH_STEPS].p <= QUARTER))
    else $error("arc cosine angle beyond a quarter turn");

  a_scaled_angles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp_q |-> (p1_q <= car_p_q.p && p2_q <= car_p_q.p))
    else $error("scaled angle exceeds full angle");

  a_sqrt_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vrt_q[SQ_STEPS] |-> (rt_q[SQ_STEPS].r[62:32] == '0))
    else $error("blend length wider than 32 bits");

endmodule

// File: bench/tb_quaternion_slerp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_top
// Self-checking bench for the fixed-point quaternion slerp block.
// ----------------------------------------------------------------------------
// A queue of quaternion pairs feeds a bursty driver; a monitor with its own
// stall pattern compares each output transaction against a bit-exact
// predictor of the slerp / normalized linear blend. The threshold register is
// rewritten between phases, each time after the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp_top;
  import qs_pkg::*;

  localparam int          PHASE_ITEMS = 150;
  localparam int          SETTLE      = 170;
  localparam int          WDOG_LIMIT  = 5000;
  localparam logic [15:0] THR_MAX     = 16'hffff;

  typedef struct {
    logic signed [15:0] a[4];
    logic signed [15:0] b[4];
    logic        [15:0] t;
  } pair_t;

  typedef struct {
    logic signed [15:0] r[4];
    logic               lin;
  } quat_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] a_in[4];
  logic signed [15:0] b_in[4];
  logic        [15:0] t_in = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic signed [15:0] r_x_o, r_y_o, r_z_o, r_w_o;
  logic               used_linear_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic        [15:0] cfg_data = '0;

  pair_t       pair_q[$];
  quat_res_t   blend_q[$];
  logic [15:0] thr_model = THR_RESET;
  int          err_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_cnt = 0;

  initial begin
    for (int i = 0; i < 4; i++) begin
      a_in[i] = '0;
      b_in[i] = '0;
    end
  end

  always #10 clk_i = ~clk_i;

  quaternion_slerp_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .a_x_i        (a_in[0]),
    .a_y_i        (a_in[1]),
    .a_z_i        (a_in[2]),
    .a_w_i        (a_in[3]),
    .b_x_i        (b_in[0]),
    .b_y_i        (b_in[1]),
    .b_z_i        (b_in[2]),
    .b_w_i        (b_in[3]),
    .t_frac_i     (t_in),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .r_x_o        (r_x_o),
    .r_y_o        (r_y_o),
    .r_z_o        (r_z_o),
    .r_w_o        (r_w_o),
    .used_linear_o(used_linear_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data)
  );

  // sine of p/65536 quarter turns, Q30
  function automatic longint unsigned sine_q30(longint unsigned p);
    longint unsigned x, x2, inner, mid;
    x = p << 14;
    x2 = (x * x) >> 30;
    inner = SIN_B - ((x2 * SIN_C) >> 30);
    mid = SIN_A - ((x2 * inner) >> 30);
    return (x * mid) >> 30;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // round half away from zero, then clip to Q1.15
  function automatic logic [15:0] round_clip(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    if (num < 0) return (q > 32768) ? SAT_NEG : 16'(-longint'(q));
    return (q > 32767) ? SAT_POS : 16'(q);
  endfunction

  function automatic quat_res_t slerp_predict(pair_t it, logic [15:0] thr);
    quat_res_t res;
    longint qa[4], qb[4], l[4];
    longint dot, t;
    longint unsigned sq, len, d, s0, s1, s2, p, p1, p2, cand;
    t = it.t;
    if (t > 32768) t = 32768;
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      qa[i] = it.a[i];
      qb[i] = it.b[i];
      dot += qa[i] * qb[i];
    end
    if (dot > longint'(thr) * 32768) begin
      sq = 0;
      for (int i = 0; i < 4; i++) begin
        l[i] = qa[i] * (32768 - t) + qb[i] * t;
        sq += longint'(l[i] * l[i]);
      end
      len = root_floor(sq);
      for (int i = 0; i < 4; i++)
        res.r[i] = (len == 0) ? 16'sd0 : round_clip(l[i] * 32768, len);
      res.lin = 1'b1;
      return res;
    end
    if (dot < 0) begin
      for (int i = 0; i < 4; i++) qa[i] = -qa[i];
      dot = -dot;
    end
    d = dot;
    if (d > ONE_Q30) d = ONE_Q30;
    p = 0;
    for (int k = 16; k >= 0; k--) begin
      cand = p | (64'd1 << k);
      if (cand <= QUARTER && sine_q30(QUARTER - cand) >= d) p = cand;
    end
    p1 = ((32768 - t) * p + 16384) >> 15;
    p2 = (t * p + 16384) >> 15;
    s0 = sine_q30(p);
    s1 = sine_q30(p1);
    s2 = sine_q30(p2);
    for (int i = 0; i < 4; i++) begin
      if (s0 == 0)
        res.r[i] = round_clip(qa[i] * (32768 - t) + qb[i] * t, 32768);
      else
        res.r[i] = round_clip(qa[i] * longint'(s1) + qb[i] * longint'(s2), s0);
    end
    res.lin = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    err_count++;
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    logic  fire, nv;
    pair_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready_o;
      if (fire) begin
        blend_q.push_back(slerp_predict(pair_q[0], thr_model));
        void'(pair_q.pop_front());
      end
      nv = in_valid && !fire;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pair_q.size() > 0) begin
          nv = 1'b1;
          nxt = pair_q[0];
          a_in <= nxt.a;
          b_in <= nxt.b;
          t_in <= nxt.t;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= nv;
    end
  end

  // monitor: check output transactions, stall on a rotating pattern
  always @(posedge clk_i or negedge rst_ni) begin
    quat_res_t want;
    logic      rdy;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (blend_q.size() == 0) begin
          report_mismatch("unexpected output", 0, 0);
        end else begin
          want = blend_q.pop_front();
          if (r_x_o !== want.r[0]) report_mismatch("r_x", r_x_o, want.r[0]);
          if (r_y_o !== want.r[1]) report_mismatch("r_y", r_y_o, want.r[1]);
          if (r_z_o !== want.r[2]) report_mismatch("r_z", r_z_o, want.r[2]);
          if (r_w_o !== want.r[3]) report_mismatch("r_w", r_w_o, want.r[3]);
          if (used_linear_o !== want.lin)
            report_mismatch("used_linear", used_linear_o, want.lin);
        end
      end
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cnt = $urandom_range(20, 200);
      end else begin
        stall_cnt--;
      end
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ($urandom_range(0, 1) != 0);
        default: rdy = ((stall_cnt % 16) < 3);
      endcase
      out_ready <= rdy;
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pair_t make_pair(int ax, int ay, int az, int aw,
                                      int bx, int by, int bz, int bw, int t);
    pair_t it;
    it.a[0] = 16'(ax); it.a[1] = 16'(ay); it.a[2] = 16'(az); it.a[3] = 16'(aw);
    it.b[0] = 16'(bx); it.b[1] = 16'(by); it.b[2] = 16'(bz); it.b[3] = 16'(bw);
    it.t = 16'(t);
    return it;
  endfunction

  function automatic pair_t random_pair();
    pair_t it;
    int    mode, amp;
    mode = $urandom_range(0, 4);
    amp = (1 << $urandom_range(0, 15)) - 1;
    for (int i = 0; i < 4; i++) begin
      it.a[i] = 16'($urandom);
      if (mode == 3) it.a[i] = 16'($urandom_range(0, 2 * 16384) - 16384);
      case (mode)
        1, 3:    it.b[i] = 16'(int'(it.a[i]) + $urandom_range(0, 2 * amp) - amp);
        2:       it.b[i] = 16'(-int'(it.a[i]) + $urandom_range(0, 2 * amp) - amp);
        default: it.b[i] = 16'($urandom);
      endcase
    end
    case ($urandom_range(0, 7))
      0:       it.t = 16'd0;
      1:       it.t = ONE_Q15;
      2, 3:    it.t = 16'($urandom);
      default: it.t = 16'($urandom_range(0, 32768));
    endcase
    return it;
  endfunction

  task automatic drain_and_write(logic [15:0] val);
    wait (pair_q.size() == 0 && blend_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    thr_model = val;
  endtask

  initial begin
    logic [15:0] thr_list[8];
    thr_list = '{16'd0, THR_MAX, 16'd32768, 16'd16384, 16'd0, 16'd30000,
                 16'd32767, THR_RESET};
    thr_list[4] = 16'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identical, opposite, zero, orthogonal, saturating and t-beyond-one cases
    pair_q.push_back(make_pair(0, 0, 0, 32767, 0, 0, 0, 32767, 16384));
    pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 16384));
    pair_q.push_back(make_pair(0, 0, 0, 32767, 0, 0, 0, -32767, 16384));
    pair_q.push_back(make_pair(0, 0, 0, 32767, 32767, 0, 0, 0, 16384));
    pair_q.push_back(make_pair(0, 0, 0, 32767, 32767, 0, 0, 0, 0));
    pair_q.push_back(make_pair(0, 0, 0, 32767, 32767, 0, 0, 0, 32768));
    pair_q.push_back(make_pair(0, 0, 0, 32767, 32767, 0, 0, 0, 65535));
    pair_q.push_back(make_pair(-32768, -32768, -32768, -32768,
                               -32768, -32768, -32768, -32768, 16384));
    pair_q.push_back(make_pair(32767, 32767, 32767, 32767,
                               -32768, -32768, -32768, -32768, 8000));
    pair_q.push_back(make_pair(32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 32767, 40000));
    pair_q.push_back(make_pair(-32768, 0, 0, 0, 32767, 0, 0, 0, 16384));
    pair_q.push_back(make_pair(23170, 0, 0, 23170, 0, 23170, 0, 23170, 16384));
    pair_q.push_back(make_pair(100, 0, 0, 0, 0, 100, 0, 0, 16384));
    pair_q.push_back(make_pair(1, 0, 0, 0, 1, 0, 0, 0, 32768));
    pair_q.push_back(make_pair(0, 0, 0, 32767, 0, 0, 50, 32767, 20000));
    pair_q.push_back(make_pair(0, 0, 0, -32767, 0, 0, 50, 32767, 20000));
    pair_q.push_back(make_pair(16384, 16384, 16384, 16384,
                               -16384, 16384, -16384, 16384, 32767));
    pair_q.push_back(make_pair(32767, -32768, 32767, -32768,
                               32767, -32768, 32767, -32768, 1));
    for (int i = 0; i < PHASE_ITEMS - 18; i++) pair_q.push_back(random_pair());

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_write(thr_list[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) pair_q.push_back(random_pair());
    end

    wait (pair_q.size() == 0 && blend_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && blend_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
